// ===== sv/lzss_window_decoder_assert.svh =====
// assertion macros for the lzss window decoder
`ifndef LZSS_WINDOW_DECODER_ASSERT_SVH
`define LZSS_WINDOW_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LZSSWD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzss window decoder: check failed");

// consequent must hold in the cycle after the antecedent
`define LZSSWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzss window decoder: check failed");

`endif

// ===== sv/lzsswd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lzsswd_pkg;

  localparam int WindowSize = 4096;
  localparam int AddrW      = $clog2(WindowSize);
  localparam int MaxMatch   = 18;
  localparam int LenW       = $clog2(MaxMatch + 1);
  localparam int CountW     = 20;
  localparam int PhaseW     = 4;

  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [AddrW-1:0]  OffsetBias = AddrW'(8'h12);
  localparam logic [7:0]        SpaceByte  = 8'h20;
  localparam logic [LenW-1:0]   MinMatch   = LenW'(3);
  localparam logic [PhaseW-1:0] LastToken  = PhaseW'(8);

  typedef struct packed {
    logic [7:0] comp_byte;
    logic       record_start;
  } comp_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last_in_run;
    logic [CountW-1:0] decoded_count;
  } dec_item_t;

endpackage

`default_nettype wire

// ===== sv/lzss_window_decoder.sv =====
// lzss window decoder
// comp channel (comp_valid / comp_ready / comp_item): one compressed byte per item,
//   with record_start set on the first byte (the flag byte) of every record
// dec channel (dec_valid / dec_ready / dec_item): one decoded byte per item, with
//   last_in_run on the final byte caused by a compressed byte and a saturating
//   running count of decoded bytes in the record
// flag bytes and first match bytes give no output and leave the sequencer idle
// a literal is accepted, then the byte goes to the output register once it is free
// a match of length 3 to 18 is copied from the 4096 x 8 history memory: the accept
//   cycle issues the first read, then one byte leaves per cycle while the output is not stalled;
//   the registered memory read is covered by issuing the next read in the
//   same cycle as the write, with a bypass when a match copies the byte just made
// comp_ready is high only while no match or literal is in progress
// when dec_ready is low the output register holds its item and the match copy
//   pauses, re-reading the current source entry each cycle until it can go on
// reset clears the control state; the history memory has no reset, entries not
//   yet written in a record read as space, and no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module lzss_window_decoder (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   comp_valid,
  output logic                        comp_ready,
  input  wire lzsswd_pkg::comp_item_t comp_item,
  output logic                        dec_valid,
  input  wire logic                   dec_ready,
  output lzsswd_pkg::dec_item_t       dec_item
);

  `include "lzss_window_decoder_assert.svh"

  localparam int AW = lzsswd_pkg::AddrW;
  localparam int LW = lzsswd_pkg::LenW;
  localparam int CW = lzsswd_pkg::CountW;
  localparam int PW = lzsswd_pkg::PhaseW;

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LIT   = 2'd1;
  localparam logic [1:0] S_MATCH = 2'd2;

  // history memory, read data registered
  logic [7:0] mem [lzsswd_pkg::WindowSize];
  logic [7:0] mem_q;

  // control state
  logic [1:0]    state, state_next;
  logic [AW-1:0] wp, wp_next;
  logic [CW-1:0] total, total_next;
  logic [7:0]    flags, flags_next;
  logic [PW-1:0] phase, phase_next;
  logic [7:0]    pending_low, pending_low_next;
  logic          awaiting, awaiting_next;
  logic [LW-1:0] remain, remain_next;
  logic [AW-1:0] src_addr, src_addr_next;
  logic [7:0]    lit_byte, lit_byte_next;
  logic          fwd_hit, fwd_hit_next;
  logic [7:0]    fwd_data;

  // datapath controls
  logic          comp_fire;
  logic          out_free;
  logic          emit;
  logic          emit_last;
  logic [7:0]    emit_byte;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] phase_eff;
  logic          is_flag;
  logic          is_second;
  logic          gate_space;
  logic [CW-1:0] total_eff;
  logic [AW-1:0] wp_eff;

  assign comp_ready = (state == S_IDLE);
  assign comp_fire  = comp_valid && comp_ready;
  assign out_free   = !dec_valid || dec_ready;

  // record start resets the token state before the byte is taken
  assign phase_eff = comp_item.record_start ? '0 : phase;
  assign is_flag   = (phase_eff == '0) || (phase_eff > lzsswd_pkg::LastToken);
  assign is_second = !is_flag && awaiting && !comp_item.record_start;

  // window entries not yet written in this record read as space
  assign gate_space = (total[CW-1:AW] == '0) && (src_addr >= total[AW-1:0]);

  always_comb begin
    state_next       = state;
    wp_next          = wp;
    total_next       = total;
    flags_next       = flags;
    phase_next       = phase;
    pending_low_next = pending_low;
    awaiting_next    = awaiting;
    remain_next      = remain;
    src_addr_next    = src_addr;
    lit_byte_next    = lit_byte;
    fwd_hit_next     = 1'b0;
    emit             = 1'b0;
    emit_last        = 1'b0;
    emit_byte        = lit_byte;
    rd_en            = 1'b0;
    rd_addr          = src_addr;
    total_eff        = total;
    wp_eff           = wp;

    case (state)
      S_IDLE: begin
        if (comp_fire) begin
          if (comp_item.record_start) begin
            total_eff     = '0;
            wp_eff        = '0;
            awaiting_next = 1'b0;
            total_next    = '0;
            wp_next       = '0;
          end
          if (is_flag) begin
            flags_next = comp_item.comp_byte;
            phase_next = PW'(1);
          end else begin
            if (awaiting || flags[0]) begin
              flags_next = flags >> 1;
              phase_next = (phase >= lzsswd_pkg::LastToken) ? '0 : phase + PW'(1);
            end
            if (awaiting) begin
              awaiting_next = 1'b0;
              rd_en         = 1'b1;
              rd_addr       = {comp_item.comp_byte[7:4], pending_low}
                              + lzsswd_pkg::OffsetBias;
              src_addr_next = rd_addr;
              remain_next   = LW'(comp_item.comp_byte[3:0]) + lzsswd_pkg::MinMatch;
              state_next    = S_MATCH;
            end else if (flags[0]) begin
              lit_byte_next = comp_item.comp_byte;
              state_next    = S_LIT;
            end else begin
              pending_low_next = comp_item.comp_byte;
              awaiting_next    = 1'b1;
            end
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_byte  = lit_byte;
          state_next = S_IDLE;
        end
      end
      S_MATCH: begin
        rd_en = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = gate_space ? lzsswd_pkg::SpaceByte : (fwd_hit ? fwd_data : mem_q);
          if (remain == LW'(1)) begin
            emit_last  = 1'b1;
            rd_en      = 1'b0;
            state_next = S_IDLE;
          end else begin
            rd_addr       = src_addr + AW'(1);
            src_addr_next = rd_addr;
            remain_next   = remain - LW'(1);
            // next source is the entry written this cycle: the read sees old data
            fwd_hit_next  = (rd_addr == wp);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      wp_next    = wp_eff + AW'(1);
      total_next = (total_eff == lzsswd_pkg::CountMax) ? total_eff : total_eff + CW'(1);
    end
  end

  // history memory: one write port at the write pointer, one read port
  always_ff @(posedge clk) begin
    if (emit) begin
      mem[wp] <= emit_byte;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      total    <= '0;
      flags    <= '0;
      phase    <= '0;
      awaiting <= 1'b0;
      remain   <= '0;
      fwd_hit  <= 1'b0;
      dec_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wp       <= wp_next;
      total    <= total_next;
      flags    <= flags_next;
      phase    <= phase_next;
      awaiting <= awaiting_next;
      remain   <= remain_next;
      fwd_hit  <= fwd_hit_next;
      if (emit) begin
        dec_valid <= 1'b1;
      end else if (dec_ready) begin
        dec_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pending_low <= pending_low_next;
    src_addr    <= src_addr_next;
    lit_byte    <= lit_byte_next;
    if (emit) begin
      fwd_data               <= emit_byte;
      dec_item.out_byte      <= emit_byte;
      dec_item.last_in_run   <= emit_last;
      dec_item.decoded_count <= total_next;
    end
  end

  // write pointer tracks the count until the window has filled once
  `LZSSWD_ASSERT_NOW(a_wp_tracks_total, clk, rst,
    total[CW-1:AW] == '0, wp == total[AW-1:0])
  // the bypass is only armed in the middle of a match copy
  `LZSSWD_ASSERT_NOW(a_fwd_in_match, clk, rst, fwd_hit, state == S_MATCH)
  // a second match byte always starts a copy
  `LZSSWD_ASSERT_NEXT(a_second_starts_match, clk, rst,
    comp_fire && is_second, state == S_MATCH && remain >= lzsswd_pkg::MinMatch)
  // the last byte of a run frees the input side
  `LZSSWD_ASSERT_NEXT(a_last_frees_input, clk, rst,
    emit && emit_last, comp_ready && dec_valid && dec_item.last_in_run)

endmodule

`default_nettype wire
